// ----- src/lis_pkg.sv -----
// ----------------------------------------------------------------------------
// lis_pkg
// Shared types and codes for the longest increasing subsequence engine.
// ----------------------------------------------------------------------------
package lis_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int INDEX_BITS  = 10;
    localparam int LENGTH_BITS = 11;
    localparam int STATUS_BITS = 2;

    // Operation codes carried in the func field
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_NO_ANSWER = 2'd3;

    typedef struct packed {
        logic                          func;
        logic signed [VALUE_BITS-1:0]  value;
        logic                          last;
        logic        [INDEX_BITS-1:0]  index;
    } t_lis_in;

    typedef struct packed {
        logic        [LENGTH_BITS-1:0] length;
        logic signed [VALUE_BITS-1:0]  element;
        logic        [STATUS_BITS-1:0] status;
    } t_lis_out;

endpackage

// ----- src/lis_ram.sv -----
// ----------------------------------------------------------------------------
// lis_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/longest_increasing_subsequence.sv -----
// ----------------------------------------------------------------------------
// longest_increasing_subsequence
// Streaming longest strictly increasing subsequence (patience method).
// ----------------------------------------------------------------------------
// Push signed values one word at a time; each push returns the current best
// length. The engine keeps two RAMs: a tail RAM (smallest tail value and its
// sample position for every length 1..MAX_ITEMS) and a sample RAM (each pushed
// value with a link to its predecessor). A push binary-searches the tail RAM,
// one read and one compare per probe, plus a predecessor lookup when the
// value lands above length one and does not repeat a tail. A push with last
// set then walks the links back from the longest tail and writes the answer
// into the tail RAM (free once the sequence ends), one sample read and one
// tail write per answer element. A read returns the answer element at
// index, or, with no RAM read, status 1 (index not below length) or 3 (no
// answer built yet). Pushes past MAX_ITEMS values are dropped with status 2.
// The next push after a last push starts a new sequence. One word is in
// flight at a time; a finished result waits in the output register while the
// next word is accepted. No RAM is cleared at reset and no clearing pass is
// needed.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence
    import lis_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_lis_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_lis_out o_out_data
);

    // Sample position, count/search bound, tail RAM address widths
    localparam int PW   = $clog2(MAX_ITEMS);
    localparam int CW   = $clog2(MAX_ITEMS + 2);
    localparam int TAW  = $clog2(MAX_ITEMS + 1);
    localparam int CMPW = (CW > LENGTH_BITS) ? CW : LENGTH_BITS;
    localparam int TW   = VALUE_BITS + PW;
    localparam int SW   = VALUE_BITS + TAW;

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH   = 4'd1;
    localparam logic [3:0] S_SWAIT  = 4'd2;
    localparam logic [3:0] S_LWAIT  = 4'd3;
    localparam logic [3:0] S_UPD    = 4'd4;
    localparam logic [3:0] S_BTAIL  = 4'd5;
    localparam logic [3:0] S_BTWAIT = 4'd6;
    localparam logic [3:0] S_BREAD  = 4'd7;
    localparam logic [3:0] S_BWAIT  = 4'd8;
    localparam logic [3:0] S_RREAD  = 4'd9;
    localparam logic [3:0] S_RWAIT  = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0]             r_state,   n_state;
    logic                   r_func,    n_func;
    logic [VALUE_BITS-1:0]  r_value,   n_value;
    logic                   r_last,    n_last;
    logic [INDEX_BITS-1:0]  r_index,   n_index;
    logic [CW-1:0]          r_cnt,     n_cnt;
    logic [CW-1:0]          r_best,    n_best;
    logic                   r_built,   n_built;
    logic [CW-1:0]          r_lo,      n_lo;
    logic [CW-1:0]          r_hi,      n_hi;
    logic [CW-1:0]          r_mid,     n_mid;
    logic [CW-1:0]          r_found,   n_found;
    logic                   r_eq,      n_eq;
    logic [TAW-1:0]         r_link,    n_link;
    logic [CW-1:0]          r_k,       n_k;
    logic [PW-1:0]          r_p,       n_p;
    logic [STATUS_BITS-1:0] r_status,  n_status;
    logic [VALUE_BITS-1:0]  r_element, n_element;
    logic                   r_out_valid, n_out_valid;
    t_lis_out               r_out_data,  n_out_data;

    // RAM ports
    logic           tail_we;
    logic [TAW-1:0] tail_waddr;
    logic [TW-1:0]  tail_wdata;
    logic [TAW-1:0] tail_raddr;
    logic [TW-1:0]  tail_rdata;
    logic           smp_we;
    logic [PW-1:0]  smp_waddr;
    logic [SW-1:0]  smp_wdata;
    logic [PW-1:0]  smp_raddr;
    logic [SW-1:0]  smp_rdata;

    logic [VALUE_BITS-1:0] tail_val;
    logic [PW-1:0]         tail_pos;
    logic [VALUE_BITS-1:0] smp_val;
    logic [TAW-1:0]        smp_link;
    logic [CW:0]           mid_sum;
    logic [CMPW-1:0]       idx_ext;
    logic                  in_fire;

    assign tail_val = tail_rdata[TW-1:PW];
    assign tail_pos = tail_rdata[PW-1:0];
    assign smp_val  = smp_rdata[SW-1:TAW];
    assign smp_link = smp_rdata[TAW-1:0];
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign idx_ext  = CMPW'(r_index);

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    lis_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_ITEMS + 1)
    ) u_tail_ram (
        .i_clk   (i_clk),
        .i_we    (tail_we),
        .i_waddr (tail_waddr),
        .i_wdata (tail_wdata),
        .i_raddr (tail_raddr),
        .o_rdata (tail_rdata)
    );

    lis_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_ITEMS)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (smp_we),
        .i_waddr (smp_waddr),
        .i_wdata (smp_wdata),
        .i_raddr (smp_raddr),
        .o_rdata (smp_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_value     = r_value;
        n_last      = r_last;
        n_index     = r_index;
        n_cnt       = r_cnt;
        n_best      = r_best;
        n_built     = r_built;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_found     = r_found;
        n_eq        = r_eq;
        n_link      = r_link;
        n_k         = r_k;
        n_p         = r_p;
        n_status    = r_status;
        n_element   = r_element;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;

        tail_we    = 1'b0;
        tail_waddr = r_found[TAW-1:0];
        tail_wdata = {r_value, r_cnt[PW-1:0]};
        tail_raddr = r_mid[TAW-1:0];
        smp_we     = 1'b0;
        smp_waddr  = r_cnt[PW-1:0];
        smp_wdata  = {r_value, r_link};
        smp_raddr  = r_p;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_func    = i_in_data.func;
                    n_value   = i_in_data.value;
                    n_last    = i_in_data.last;
                    n_index   = i_in_data.index;
                    n_status  = ST_OK;
                    n_element = '0;
                    if (i_in_data.func == FUNC_PUSH) begin
                        // Fresh sequence: drop the old length and answer
                        if (r_cnt == '0) begin
                            n_best  = '0;
                            n_built = 1'b0;
                        end
                        if (r_cnt >= CW'(MAX_ITEMS)) begin
                            n_status = ST_FULL;
                            n_state  = i_in_data.last ? S_BTAIL : S_DONE;
                        end else begin
                            n_lo    = CW'(1);
                            n_hi    = n_best;
                            n_found = n_best + CW'(1);
                            n_eq    = 1'b0;
                            n_link  = '0;
                            n_state = S_SRCH;
                        end
                    end else begin
                        if (!r_built) begin
                            n_status = ST_NO_ANSWER;
                            n_state  = S_DONE;
                        end else if (CMPW'(i_in_data.index) >= CMPW'(r_best)) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_RREAD;
                        end
                    end
                end
            end
            S_SRCH: begin
                if (r_lo <= r_hi) begin
                    // Issue the probe read now so the tail lands in S_SWAIT
                    n_mid      = mid_sum[CW:1];
                    tail_raddr = TAW'(mid_sum[CW:1]);
                    n_state    = S_SWAIT;
                end else if (r_eq) begin
                    n_state = S_UPD;
                end else if (r_found > CW'(1)) begin
                    // Fetch the tail position one length shorter for the link
                    tail_raddr = TAW'(r_found - CW'(1));
                    n_state    = S_LWAIT;
                end else begin
                    n_link  = '0;
                    n_state = S_UPD;
                end
            end
            S_SWAIT: begin
                if ($signed(tail_val) >= $signed(r_value)) begin
                    n_found = r_mid;
                    n_hi    = r_mid - CW'(1);
                    n_eq    = (tail_val == r_value);
                end else begin
                    n_lo = r_mid + CW'(1);
                end
                n_state = S_SRCH;
            end
            S_LWAIT: begin
                n_link  = TAW'(tail_pos) + TAW'(1);
                n_state = S_UPD;
            end
            S_UPD: begin
                smp_we  = 1'b1;
                tail_we = !r_eq;
                if (!r_eq && (r_found > r_best)) begin
                    n_best = r_found;
                end
                n_cnt   = r_cnt + CW'(1);
                n_state = r_last ? S_BTAIL : S_DONE;
            end
            S_BTAIL: begin
                if (r_best == '0) begin
                    n_built = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    tail_raddr = r_best[TAW-1:0];
                    n_k        = r_best;
                    n_state    = S_BTWAIT;
                end
            end
            S_BTWAIT: begin
                n_p     = tail_pos;
                n_state = S_BREAD;
            end
            S_BREAD: begin
                smp_raddr = r_p;
                n_state   = S_BWAIT;
            end
            S_BWAIT: begin
                // Answer element k-1 lands at tail entry k
                tail_we    = 1'b1;
                tail_waddr = r_k[TAW-1:0];
                tail_wdata = {smp_val, r_p};
                n_k        = r_k - CW'(1);
                if ((r_k == CW'(1)) || (smp_link == '0)) begin
                    n_built = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_p     = PW'(smp_link - TAW'(1));
                    n_state = S_BREAD;
                end
            end
            S_RREAD: begin
                tail_raddr = TAW'(idx_ext + CMPW'(1));
                n_state    = S_RWAIT;
            end
            S_RWAIT: begin
                n_element = tail_val;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid        = 1'b1;
                    n_out_data.length  = LENGTH_BITS'(r_best);
                    n_out_data.element = r_element;
                    n_out_data.status  = r_status;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_best      <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_best      <= n_best;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
        r_func     <= n_func;
        r_value    <= n_value;
        r_last     <= n_last;
        r_index    <= n_index;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_found    <= n_found;
        r_eq       <= n_eq;
        r_link     <= n_link;
        r_k        <= n_k;
        r_p        <= n_p;
        r_status   <= n_status;
        r_element  <= n_element;
        r_out_data <= n_out_data;
    end

    // Length and fill count never pass the capacity
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best <= CW'(MAX_ITEMS)) && (r_cnt <= CW'(MAX_ITEMS)))
        else $error("length or count beyond capacity");

    // Every probe of the search lies inside the current table
    a_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAIT) |-> ((r_mid >= CW'(1)) && (r_mid <= r_best)))
        else $error("search probe outside tail table");

    // A finished last push leaves a built answer and a fresh count
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (r_func == FUNC_PUSH) && r_last)
            |-> (r_built && (r_cnt == '0)))
        else $error("last push did not build the answer");

    // The answer walk stays within the built length
    a_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BWAIT) |-> ((r_k >= CW'(1)) && (r_k <= r_best)))
        else $error("answer walk out of range");

endmodule

// ----- bench/longest_increasing_subsequence_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_tb
// Self-checking bench for the streaming longest increasing subsequence engine.
// ----------------------------------------------------------------------------
// Directed tests cover reads before any answer, the value extremes, equal
// values, single-value sequences, reads in the middle of a sequence and a full
// sample store with dropped pushes. A random part then streams about 200
// words, mostly whole sequences followed by reads. A predictor in the bench
// tracks the tail table and links and queues one expected word per accepted
// word. The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_tb;
    import lis_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int RANDOM_WORDS = 200;
    // Slowest realistic word: a full search, a long receiver stall and a sender
    // gap; answer builds add a walk over every answer element.
    // About 1300 words in all, so the limit leaves a wide margin.
    localparam int CYCLE_LIMIT  = 2_000_000;
    // After the last expected word, watch a little longer for stray words.
    localparam int DRAIN_CYCLES = 200;

    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    typedef enum int {VS_FULL, VS_NARROW, VS_RISING, VS_FALLING, VS_CORNER} t_value_style;
    typedef enum int {RX_STEADY, RX_COIN, RX_CHOKE, RX_BEAT} t_rx_mode;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_ready;
    t_lis_in  i_in_data   = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_lis_out o_out_data;

    longest_increasing_subsequence #(
        .MAX_ITEMS(DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: samples, smallest tail per length, links, answer
    // ------------------------------------------------------------------------
    bit signed [VALUE_BITS-1:0] seq_vals    [DEPTH];
    bit signed [VALUE_BITS-1:0] tail_val    [DEPTH+1];
    int                         tail_pos    [DEPTH+1];
    int                         back_link   [DEPTH];   // position+1, zero = none
    bit signed [VALUE_BITS-1:0] answer_vals [DEPTH];
    int                         held_count   = 0;
    int                         best_len     = 0;
    bit                         answer_built = 1'b0;

    t_lis_out lis_expected[$];   // expected result words, oldest first
    int       mismatches  = 0;
    int       words_sent  = 0;
    int       burst_left  = 1;
    int       cycle_count = 0;
    logic signed [VALUE_BITS-1:0] walk_value = '0;

    // Advance the predictor by one accepted word and return the word it owes.
    function automatic t_lis_out predict_word(input t_lis_in w);
        t_lis_out r;
        bit signed [VALUE_BITS-1:0] v;
        int lo, hi, mid, found, here, k, p;
        bit walking;
        r = '0;
        v = w.value;
        if (w.func == FUNC_PUSH) begin
            // A push after a finished sequence starts a fresh one
            if (held_count == 0) begin
                best_len     = 0;
                answer_built = 1'b0;
            end
            if (held_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                here           = held_count;
                seq_vals[here] = v;
                lo    = 1;
                hi    = best_len;
                found = best_len + 1;
                // Find the first length whose tail is not below the value
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (tail_val[mid] >= v) begin
                        found = mid;
                        hi    = mid - 1;
                    end else begin
                        lo = mid + 1;
                    end
                end
                // An equal tail leaves the table as it is
                if (found > best_len || tail_val[found] != v) begin
                    tail_val[found] = v;
                    tail_pos[found] = here;
                    back_link[here] = (found > 1) ? tail_pos[found-1] + 1 : 0;
                    if (found > best_len)
                        best_len = found;
                end
                held_count = here + 1;
            end
            if (w.last) begin
                // Walk the links back from the longest tail
                k       = best_len;
                walking = (k > 0);
                p       = walking ? tail_pos[k] : 0;
                while (walking && k > 0) begin
                    answer_vals[k-1] = seq_vals[p];
                    k = k - 1;
                    if (back_link[p] == 0)
                        walking = 1'b0;
                    else
                        p = back_link[p] - 1;
                end
                answer_built = 1'b1;
                held_count   = 0;
            end
        end else begin
            if (!answer_built)
                r.status = ST_NO_ANSWER;
            else if (int'(w.index) >= best_len)
                r.status = ST_RANGE;
            else
                r.element = answer_vals[w.index];
        end
        r.length = LENGTH_BITS'(best_len);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Sender: hold valid and the word until accepted, idle between bursts
    // ------------------------------------------------------------------------
    task automatic send_word(input t_lis_in w);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        lis_expected.push_back(predict_word(w));
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            // Drop valid for a gap, then pick the next burst length
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Unused fields of each word carry random bits.
    task automatic push_word(input logic signed [VALUE_BITS-1:0] v, input logic lst);
        t_lis_in w;
        w.func  = FUNC_PUSH;
        w.value = v;
        w.last  = lst;
        w.index = INDEX_BITS'($urandom);
        send_word(w);
    endtask

    task automatic read_word(input int idx);
        t_lis_in w;
        w.func  = FUNC_READ;
        w.value = $urandom;
        w.last  = 1'($urandom_range(0, 1));
        w.index = idx[INDEX_BITS-1:0];
        send_word(w);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] next_value(input t_value_style s);
        case (s)
            VS_NARROW:  return int'($urandom_range(0, 30)) - 15;
            VS_RISING:  begin walk_value = walk_value + $urandom_range(0, 4); return walk_value; end
            VS_FALLING: begin walk_value = walk_value - $urandom_range(0, 4); return walk_value; end
            VS_CORNER: begin
                case ($urandom_range(0, 4))
                    0:       return VALUE_MIN;
                    1:       return VALUE_MAX;
                    2:       return '0;
                    3:       return -1;
                    default: return $urandom;
                endcase
            end
            default:    return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: check each accepted word, stall on a pattern of its own
    // ------------------------------------------------------------------------
    task automatic check_result(input t_lis_out got);
        t_lis_out want;
        if (lis_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected word length %0d element %0d status %0d",
                                      got.length, got.element, got.status));
        end else begin
            want = lis_expected.pop_front();
            if (got.length !== want.length)
                report_mismatch($sformatf("length %0d, expected %0d", got.length, want.length));
            if (got.element !== want.element)
                report_mismatch($sformatf("element %0d, expected %0d",
                                          got.element, want.element));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        end
    endtask

    t_rx_mode rx_mode  = RX_STEADY;
    int       rx_timer = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_result(o_out_data);
            // Switch stall mode when the mode timer runs out
            if (rx_timer == 0) begin
                rx_mode  <= t_rx_mode'($urandom_range(0, 3));
                rx_timer <= $urandom_range(16, 96);
            end else begin
                rx_timer <= rx_timer - 1;
            end
            case (rx_mode)
                RX_STEADY: i_out_ready <= 1'b1;
                RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                RX_CHOKE:  i_out_ready <= ($urandom_range(0, 7) == 0);
                default:   i_out_ready <= rx_timer[1];
            endcase
        end
    end

    // Cap the run in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d words outstanding", $time, lis_expected.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // No answer exists yet after reset.
    task automatic test_read_before_answer();
        read_word(0);
        read_word(DEPTH - 1);
    endtask

    // Extremes of the value range, equal values skipped, reads up to and past
    // the length.
    task automatic test_push_extremes();
        int i;
        push_word(5, 1'b0);
        push_word(5, 1'b0);
        push_word(VALUE_MIN, 1'b0);
        push_word(VALUE_MAX, 1'b0);
        push_word(VALUE_MAX, 1'b0);
        push_word(0, 1'b0);
        push_word(-1, 1'b0);
        push_word(7, 1'b1);
        for (i = 0; i <= best_len; i++)
            read_word(i);
        read_word(DEPTH - 1);
    endtask

    // A one-value sequence; the answer is length one.
    task automatic test_single_push();
        push_word(42, 1'b1);
        read_word(0);
        read_word(1);
    endtask

    // A fresh start hides the old answer until the new sequence ends.
    task automatic test_read_mid_sequence();
        push_word(-3, 1'b0);
        read_word(0);
        push_word(9, 1'b1);
        read_word(1);
    endtask

    // Fill the sample store with a rising run, drop pushes past the end, build
    // the answer from a dropped last push, then start over.
    task automatic test_fill_and_drop();
        int i;
        for (i = 0; i < DEPTH; i++)
            push_word(VALUE_BITS'(i * 3 - 1500), 1'b0);
        push_word($urandom, 1'b0);
        push_word($urandom, 1'b0);
        push_word(VALUE_MIN, 1'b1);
        read_word(0);
        read_word(DEPTH / 2);
        read_word(DEPTH - 1);
        push_word(VALUE_MAX, 1'b1);
        read_word(0);
        read_word(1);
    endtask

    // Mostly whole sequences with random content and reads afterwards; some
    // stray reads and pushes, and reads dropped into open sequences.
    task automatic test_random_sequences(input int n_words);
        int start, len, i, n_reads, mid_read, top;
        t_value_style style;
        start = words_sent;
        while (words_sent - start < n_words) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1))
                    read_word($urandom_range(0, DEPTH - 1));
                else
                    push_word($urandom, 1'b0);
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160)
                                                  : $urandom_range(1, 40);
                style      = t_value_style'($urandom_range(0, 4));
                walk_value = $urandom;
                mid_read   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
                for (i = 0; i < len; i++) begin
                    if (i == mid_read)
                        read_word($urandom_range(0, DEPTH - 1));
                    push_word(next_value(style), i == len - 1);
                end
                n_reads = $urandom_range(1, 6);
                top     = (best_len < DEPTH) ? best_len : DEPTH - 1;
                for (i = 0; i < n_reads; i++) begin
                    if ($urandom_range(0, 3) == 0)
                        read_word($urandom_range(0, DEPTH - 1));
                    else
                        read_word($urandom_range(0, top));
                end
            end
        end
    endtask

    initial begin
        burst_left = $urandom_range(1, 12);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_read_before_answer();
        test_push_extremes();
        test_single_push();
        test_read_mid_sequence();
        test_fill_and_drop();
        test_random_sequences(RANDOM_WORDS);

        // Drop valid, wait for every expected word, then watch for strays
        i_in_valid <= 1'b0;
        while (lis_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
